// File: design/gcbg_pkg.sv
// ----------------------------------------------------------------------------
// gcbg_pkg
// Shared types, register indexes and CRC form conversions for the
// bit-granular CRC engine.
// ----------------------------------------------------------------------------
package gcbg_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CRC_WIDTH   = 3'd0,
		REG_POLY_WORD   = 3'd1,
		REG_REFLECT_IN  = 3'd2,
		REG_REFLECT_OUT = 3'd3,
		REG_XOR_OUT     = 3'd4
	} reg_index_t;

	// decoded configuration shared by front and back
	typedef struct packed {
		logic [6:0]  width;   // effective width, 1..64
		logic [5:0]  shift;   // 64 - width
		logic [63:0] mask;    // low width bits set
		logic [63:0] poly;
		logic        refin;
		logic        refout;
		logic [63:0] xorout;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [7:0]  data;    // masked valid bits, in place
		logic [3:0]  count;   // valid bits, 0..8
		logic        first;
		logic        last;
		logic [63:0] start;   // start value already in internal form
	} q_word_t;

	// full 64-bit reversal
	function automatic logic [63:0] reverse64(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = v[63-i];
		end
		return r;
	endfunction

	// user form to internal form
	function automatic logic [63:0] to_internal(input cfg_t c, input logic [63:0] v);
		logic [63:0] t;
		t = (v ^ c.xorout) & c.mask;
		if (c.refin != c.refout) begin
			t = reverse64(t) >> c.shift;
		end
		if (!c.refin) begin
			t = t << c.shift;
		end
		return t;
	endfunction

	// internal form back to user form
	function automatic logic [63:0] from_internal(input cfg_t c, input logic [63:0] v);
		logic [63:0] t;
		t = v;
		if (!c.refin) begin
			t = t >> c.shift;
		end
		if (c.refin != c.refout) begin
			t = reverse64(t) >> c.shift;
		end
		return (t ^ c.xorout) & c.mask;
	endfunction

endpackage

// File: design/generic_crc_bit_granular.sv
// ----------------------------------------------------------------------------
// generic_crc_bit_granular
// Configurable CRC engine, width 1 to 64, fed one byte of 0 to 8 valid bits
// per word.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one CRC per word flagged last, in
// order, with a steady rate of one word per cycle while out_ready lets the
// output drain. The rate is set by the update unit in the back part, which
// runs up to eight shift-and-xor steps of a word combinationally. A last word
// passes the input register, the queue, the result register and the output
// register, where it is converted to user form, before it shows on crc_value.
// Configuration writes must be made while the engine is idle; poly_word is
// given in internal form (reflected in the low bits, or left-aligned to bit
// 63), and the CRC is returned in the low crc_width bits.
// ----------------------------------------------------------------------------
module generic_crc_bit_granular #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  bit_count,
	input  logic        first,
	input  logic        last,
	input  logic [63:0] start_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] crc_value
);

	logic [6:0]        crc_width_q;
	logic [63:0]       poly_word_q;
	logic              reflect_in_q;
	logic              reflect_out_q;
	logic [63:0]       xor_out_q;
	logic [6:0]        eff_w;
	gcbg_pkg::cfg_t    cfg;
	logic              fq_valid;
	logic              fq_ready;
	gcbg_pkg::q_word_t fq_word;
	logic              qb_valid;
	logic              qb_ready;
	gcbg_pkg::q_word_t qb_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_width_q   <= 7'd32;
			poly_word_q   <= 64'h0000_0000_EDB8_8320;
			reflect_in_q  <= 1'b1;
			reflect_out_q <= 1'b1;
			xor_out_q     <= 64'h0000_0000_FFFF_FFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcbg_pkg::REG_CRC_WIDTH:   crc_width_q   <= cfg_data[6:0];
				gcbg_pkg::REG_POLY_WORD:   poly_word_q   <= cfg_data;
				gcbg_pkg::REG_REFLECT_IN:  reflect_in_q  <= cfg_data[0];
				gcbg_pkg::REG_REFLECT_OUT: reflect_out_q <= cfg_data[0];
				gcbg_pkg::REG_XOR_OUT:     xor_out_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp width and derive shift and mask
	always_comb begin
		if (crc_width_q == 7'd0) begin
			eff_w = 7'd1;
		end else if (crc_width_q > 7'd64) begin
			eff_w = 7'd64;
		end else begin
			eff_w = crc_width_q;
		end
		cfg.width  = eff_w;
		cfg.shift  = 6'(7'd64 - eff_w);
		cfg.mask   = ~({64{1'b1}} << eff_w);
		cfg.poly   = poly_word_q;
		cfg.refin  = reflect_in_q;
		cfg.refout = reflect_out_q;
		cfg.xorout = xor_out_q;
	end

	gcbg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.bit_count   (bit_count),
		.first       (first),
		.last        (last),
		.start_value (start_value),
		.cfg         (cfg),
		.out_valid   (fq_valid),
		.out_ready   (fq_ready),
		.out_word    (fq_word)
	);

	gcbg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_word  (fq_word),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_word   (qb_word)
	);

	gcbg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_word    (qb_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.crc_value (crc_value)
	);

endmodule

// File: design/gcbg_front.sv
// ----------------------------------------------------------------------------
// gcbg_front
// Input stage: takes a word, clamps the bit count, masks the valid data bits
// and moves the start value into internal form, then hands it to the queue.
// ----------------------------------------------------------------------------
module gcbg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	input  logic [3:0]       bit_count,
	input  logic             first,
	input  logic             last,
	input  logic [63:0]      start_value,
	input  gcbg_pkg::cfg_t   cfg,
	output logic             out_valid,
	input  logic             out_ready,
	output gcbg_pkg::q_word_t out_word
);

	logic              valid_s1;
	gcbg_pkg::q_word_t word_s1;
	gcbg_pkg::q_word_t word_d;
	logic [3:0]        cnt;
	logic [7:0]        dmask;

	// clamp count and build the valid-bit mask
	always_comb begin
		cnt = (bit_count > 4'd8) ? 4'd8 : bit_count;
		if (cfg.refin) begin
			dmask = 8'hff >> (4'd8 - cnt);
		end else begin
			dmask = 8'hff << (4'd8 - cnt);
		end
		word_d.data  = data_byte & dmask;
		word_d.count = cnt;
		word_d.first = first;
		word_d.last  = last;
		word_d.start = gcbg_pkg::to_internal(cfg, start_value);
	end

	// stage register ahead of the queue
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= word_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

// File: design/gcbg_queue.sv
// ----------------------------------------------------------------------------
// gcbg_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module gcbg_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  gcbg_pkg::q_word_t push_word,
	output logic              pop_valid,
	input  logic              pop_ready,
	output gcbg_pkg::q_word_t pop_word
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	gcbg_pkg::q_word_t entry_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_word   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("empty queue with unequal pointers");

endmodule

// File: design/gcbg_back.sv
// ----------------------------------------------------------------------------
// gcbg_back
// CRC update unit: runs up to eight shift-and-xor steps per word on the
// internal register, then converts finished values to user form through a
// result stage and an output register.
// ----------------------------------------------------------------------------
module gcbg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gcbg_pkg::cfg_t    cfg,
	input  logic              q_valid,
	output logic              q_ready,
	input  gcbg_pkg::q_word_t q_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       crc_value
);

	logic [63:0] crc_q;
	logic [63:0] crc_d;
	logic        res_valid_s1;
	logic [63:0] res_s1;
	logic        out_valid_q;
	logic [63:0] out_q;
	logic        res_ready;
	logic        out_slot_ready;
	logic        pop;

	// stall chain from the output back to the queue
	assign out_slot_ready = !out_valid_q || out_ready;
	assign res_ready      = !res_valid_s1 || out_slot_ready;
	assign q_ready        = res_ready;
	assign pop            = q_valid && res_ready;

	// load, inject data and run the per-bit steps
	always_comb begin
		crc_d = q_word.first ? q_word.start : crc_q;
		if (cfg.refin) begin
			crc_d = crc_d ^ {56'd0, q_word.data};
		end else begin
			crc_d = crc_d ^ {q_word.data, 56'd0};
		end
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < q_word.count) begin
				if (cfg.refin) begin
					crc_d = (crc_d >> 1) ^ (cfg.poly & {64{crc_d[0]}});
				end else begin
					crc_d = (crc_d << 1) ^ (cfg.poly & {64{crc_d[63]}});
				end
			end
		end
	end

	// crc register and result valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= '0;
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				crc_q <= crc_d;
			end
			if (res_ready) begin
				res_valid_s1 <= pop && q_word.last;
			end
			if (out_slot_ready) begin
				out_valid_q <= res_valid_s1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && q_word.last) begin
			res_s1 <= crc_d;
		end
		if (res_valid_s1 && out_slot_ready) begin
			out_q <= gcbg_pkg::from_internal(cfg, res_s1);
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = out_q;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s1 && !out_slot_ready) |=> res_valid_s1)
		else $error("pending result dropped while output stalled");

	a_first_load: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_word.first && (q_word.count == 4'd0) && (q_word.data == 8'd0))
		|=> (crc_q == $past(q_word.start)))
		else $error("start value not loaded on first word");

endmodule
